// File: sv/hee_pkg.sv
package hee_pkg;

    // Width of one text code unit on both streams.
    localparam int UNIT_W = 16;
    // Position counter inside an escape sequence (up to six units).
    localparam int IDX_W = 3;
    localparam int QM_W = 2;

    // Quote mode register codes.
    localparam logic [QM_W-1:0] QM_NONE   = 2'd0;
    localparam logic [QM_W-1:0] QM_DOUBLE = 2'd1;
    localparam logic [QM_W-1:0] QM_BOTH   = 2'd2;
    localparam logic [QM_W-1:0] QM_RESET  = QM_DOUBLE;

    // Characters used by the escapes.
    localparam logic [UNIT_W-1:0] CH_AMP   = 16'h0026;
    localparam logic [UNIT_W-1:0] CH_LT    = 16'h003C;
    localparam logic [UNIT_W-1:0] CH_GT    = 16'h003E;
    localparam logic [UNIT_W-1:0] CH_DQ    = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_SQ    = 16'h0027;
    localparam logic [UNIT_W-1:0] CH_SEMI  = 16'h003B;
    localparam logic [UNIT_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [UNIT_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_THREE = 16'h0033;
    localparam logic [UNIT_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [UNIT_W-1:0] CH_A     = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_G     = 16'h0067;
    localparam logic [UNIT_W-1:0] CH_L     = 16'h006C;
    localparam logic [UNIT_W-1:0] CH_M     = 16'h006D;
    localparam logic [UNIT_W-1:0] CH_O     = 16'h006F;
    localparam logic [UNIT_W-1:0] CH_P     = 16'h0070;
    localparam logic [UNIT_W-1:0] CH_Q     = 16'h0071;
    localparam logic [UNIT_W-1:0] CH_T     = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_U     = 16'h0075;

    // What an accepted unit turns into.
    typedef enum logic [2:0] {
        K_PASS,
        K_AMP,
        K_LT,
        K_GT,
        K_QUOT,
        K_APOS
    } t_kind;

    // Decide how a unit is escaped under the given quote mode.
    function automatic t_kind classify(input logic [UNIT_W-1:0] unit,
                                       input logic [QM_W-1:0] qmode);
        t_kind k;
        priority if (unit == CH_AMP) k = K_AMP;
        else if (unit == CH_LT) k = K_LT;
        else if (unit == CH_GT) k = K_GT;
        else if (unit == CH_DQ && (qmode == QM_DOUBLE || qmode == QM_BOTH)) k = K_QUOT;
        else if (unit == CH_SQ && qmode == QM_BOTH) k = K_APOS;
        else k = K_PASS;
        return k;
    endfunction

    // Number of output units for each kind.
    function automatic logic [IDX_W-1:0] seq_len(input t_kind k);
        logic [IDX_W-1:0] n;
        unique case (k)
            K_PASS:  n = 3'd1;
            K_AMP:   n = 3'd5;
            K_LT:    n = 3'd4;
            K_GT:    n = 3'd4;
            K_QUOT:  n = 3'd6;
            K_APOS:  n = 3'd6;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

    // Output unit at a position of the sequence; a pass-through gives the unit itself.
    function automatic logic [UNIT_W-1:0] seq_unit(input t_kind k,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [UNIT_W-1:0] unit);
        logic [UNIT_W-1:0] c;
        c = CH_SEMI;
        unique case (k)
            K_PASS: c = unit;
            K_AMP: begin
                unique case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_A;
                    3'd2:    c = CH_M;
                    3'd3:    c = CH_P;
                    default: c = CH_SEMI;
                endcase
            end
            K_LT: begin
                unique case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_L;
                    3'd2:    c = CH_T;
                    default: c = CH_SEMI;
                endcase
            end
            K_GT: begin
                unique case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_G;
                    3'd2:    c = CH_T;
                    default: c = CH_SEMI;
                endcase
            end
            K_QUOT: begin
                unique case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_Q;
                    3'd2:    c = CH_U;
                    3'd3:    c = CH_O;
                    3'd4:    c = CH_T;
                    default: c = CH_SEMI;
                endcase
            end
            K_APOS: begin
                unique case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_HASH;
                    3'd2:    c = CH_ZERO;
                    3'd3:    c = CH_THREE;
                    3'd4:    c = CH_NINE;
                    default: c = CH_SEMI;
                endcase
            end
            default: c = unit;
        endcase
        return c;
    endfunction

endpackage

// File: sv/html_entity_escape.sv
// HTML special-character escaper for a stream of 16-bit code units. Each
// request on the slave stream carries one unit; the master stream returns
// its escaped form one unit per request, with tlast on the final unit of
// each run. Ordinary units pass at one per cycle unless the master stream
// stalls, via the item register and then the output register. An escaped unit
// becomes a sequence of 4 units for &lt; and &gt;, 5 for &amp; and 6 for &quot;
// and &#039;, which the single output register emits one unit per cycle unless
// stalled; the next input is taken in the cycle the final unit is loaded. The
// quote mode register (reset 1) is written through the cfg channel, which is
// always ready, and should only change while the block is idle.
module html_entity_escape (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // cfg: quote_mode in bits [1:0]
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hee_pkg::QM_W-1:0]   i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: in_unit [15:0]
    input  logic [hee_pkg::UNIT_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata: out_unit [15:0]
    output logic [hee_pkg::UNIT_W-1:0] m_axis_tdata,
    // tlast: last_of_run
    output logic                       m_axis_tlast
);
    import hee_pkg::*;

    logic [QM_W-1:0]   r_qmode;
    logic              r_busy;
    t_kind             r_kind;
    logic [UNIT_W-1:0] r_unit;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [UNIT_W-1:0] r_out_data;
    logic              r_out_last;

    logic              adv;
    logic              item_last;
    logic              in_take;

    // Quote mode register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode <= QM_RESET;
        end else if (i_cfg_valid) begin
            r_qmode <= i_cfg_data;
        end
    end

    // Move one unit from the item register to the output register when it is free.
    assign adv           = r_busy && (!r_out_valid || m_axis_tready);
    assign item_last     = (r_idx == seq_len(r_kind) - 3'd1);
    assign s_axis_tready = !r_busy || (adv && item_last);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Item register: the unit being escaped and its position in the sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (in_take) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (adv && item_last) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= classify(s_axis_tdata, r_qmode);
            r_unit <= s_axis_tdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= seq_unit(r_kind, r_idx, r_unit);
            r_out_last <= item_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: sv/hee_checker.sv
module hee_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [hee_pkg::UNIT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tlast
);
    import hee_pkg::*;

    logic m_take;
    assign m_take = m_axis_tvalid && m_axis_tready;

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // An ampersand is always escaped, so it never ends a run.
    a_amp_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata == CH_AMP |-> !m_axis_tlast)
        else $error("ampersand ended a run");

    // The rest of an escape follows without a gap.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_take && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside an escape sequence");

    // The second unit of an escape is one of the known entity letters or the hash sign.
    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_take && !m_axis_tlast && m_axis_tdata == CH_AMP |=>
            (m_axis_tdata == CH_A || m_axis_tdata == CH_L || m_axis_tdata == CH_G ||
             m_axis_tdata == CH_Q || m_axis_tdata == CH_HASH))
        else $error("unexpected unit after ampersand");

endmodule

bind html_entity_escape hee_checker u_hee_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/html_entity_escape_test.sv
`timescale 1ns / 100ps

module html_entity_escape_test;
    import hee_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // Margin to let the pipeline settle after the last expected unit has come out.
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_MODE = 62;
    // The fourth quote mode code has no name in the package; it must act like no quotes.
    localparam logic [QM_W-1:0] QM_UNDEF = 2'd3;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } t_esc_unit;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [QM_W-1:0]   i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [UNIT_W-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [UNIT_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;

    t_esc_unit       expected_units[$];
    t_esc_unit       oldest_unit;
    logic [QM_W-1:0] quote_mode_copy;
    bit              steady_flow;
    int              stall_left;
    int              cycle_count;
    int              errors;
    int              units_sent;
    int              escapes_predicted;
    int              units_checked;
    int              mode_writes;

    html_entity_escape uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Expected escape of one accepted unit under the current quote mode.
    task automatic predict_escape(input logic [UNIT_W-1:0] unit);
        string     entity;
        t_esc_unit e;
        entity = "";
        if (unit == CH_AMP) entity = "&amp;";
        else if (unit == CH_LT) entity = "&lt;";
        else if (unit == CH_GT) entity = "&gt;";
        else if (unit == CH_DQ &&
                 (quote_mode_copy == QM_DOUBLE || quote_mode_copy == QM_BOTH))
            entity = "&quot;";
        else if (unit == CH_SQ && quote_mode_copy == QM_BOTH) entity = "&#039;";

        if (entity.len() == 0) begin
            e.unit = unit;
            e.last = 1'b1;
            expected_units.push_back(e);
        end else begin
            escapes_predicted++;
            for (int k = 0; k < entity.len(); k++) begin
                e.unit = {8'h00, entity[k]};
                e.last = (k == entity.len() - 1);
                expected_units.push_back(e);
            end
        end
    endtask

    // Mostly back-to-back requests, some short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Send one text unit and predict its escape once the request is taken.
    task automatic send_unit(input logic [UNIT_W-1:0] unit);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = unit;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_escape(unit);
        units_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait until every expected unit has come out, then let the pipeline settle.
    task automatic wait_idle();
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_quote_mode(input logic [QM_W-1:0] mode);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        quote_mode_copy = mode;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Special characters, near misses that differ in one bit, or any unit at all.
    function automatic logic [UNIT_W-1:0] random_unit();
        logic [UNIT_W-1:0] special;
        int                r;
        case ($urandom_range(0, 4))
            0:       special = CH_AMP;
            1:       special = CH_LT;
            2:       special = CH_GT;
            3:       special = CH_DQ;
            default: special = CH_SQ;
        endcase
        r = $urandom_range(0, 99);
        if (r < 40) return special;
        if (r < 55) return special ^ (16'h0001 << $urandom_range(0, 15));
        return UNIT_W'($urandom_range(0, 65535));
    endfunction

    // Every special character and the field extremes under the quote mode left by reset.
    task automatic test_reset_mode();
        send_unit(CH_AMP);
        send_unit(CH_LT);
        send_unit(CH_GT);
        send_unit(CH_DQ);
        send_unit(CH_SQ);
        send_unit(16'h0000);
        send_unit(16'hFFFF);
        send_unit(CH_A);
        stop_sending();
    endtask

    // Both quote kinds under the other quote modes, plus units one bit off a special.
    task automatic test_quote_modes();
        write_quote_mode(QM_NONE);
        send_unit(CH_DQ);
        send_unit(CH_SQ);
        send_unit(CH_AMP);
        stop_sending();

        write_quote_mode(QM_BOTH);
        send_unit(CH_SQ);
        send_unit(CH_DQ);
        send_unit(CH_GT);
        send_unit(CH_AMP | 16'h8000);
        send_unit(CH_SQ | 16'h0100);
        send_unit(CH_LT ^ 16'h0001);
        stop_sending();

        write_quote_mode(QM_UNDEF);
        send_unit(CH_DQ);
        send_unit(CH_SQ);
        send_unit(CH_LT);
        stop_sending();
    endtask

    // Random text under each quote mode, with one stretch free of gaps and stalls.
    task automatic test_random_text();
        logic [QM_W-1:0] modes[4];
        modes[0] = QM_BOTH;
        modes[1] = QM_NONE;
        modes[2] = QM_UNDEF;
        modes[3] = QM_DOUBLE;
        for (int m = 0; m < 4; m++) begin
            write_quote_mode(modes[m]);
            for (int i = 0; i < ITEMS_PER_MODE; i++) begin
                steady_flow = (m == 1) && (i < ITEMS_PER_MODE / 2);
                send_unit(random_unit());
            end
            steady_flow = 1'b0;
            stop_sending();
        end
    endtask

    // Receiver stalls: mostly ready, some short stalls and a few long ones.
    always @(negedge i_clk) begin
        if (!steady_flow && stall_left == 0 && $urandom_range(0, 99) < 20) begin
            if ($urandom_range(0, 9) < 8) stall_left = $urandom_range(1, 3);
            else stall_left = $urandom_range(4, 20);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each output unit with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_units.size() == 0) begin
                $error("unexpected output unit: out_unit %h last_of_run %b",
                       m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                oldest_unit = expected_units.pop_front();
                units_checked++;
                if (m_axis_tdata !== oldest_unit.unit) begin
                    $error("out_unit: expected %h, actual %h", oldest_unit.unit, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== oldest_unit.last) begin
                    $error("last_of_run: expected %b, actual %b",
                           oldest_unit.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles.", cycle_count);
            $display("** html_entity_escape: FAILED **");
            $finish;
        end
    end

    // Reset, then the tests in turn.
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = QM_NONE;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        quote_mode_copy = QM_RESET;
        steady_flow     = 1'b0;
        stall_left      = 0;
        cycle_count     = 0;
        errors          = 0;
        units_sent      = 0;
        escapes_predicted = 0;
        units_checked   = 0;
        mode_writes     = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_mode();
        test_quote_modes();
        test_random_text();
        wait_idle();

        $display("Sent %0d text units, %0d of them escaped, across %0d quote mode writes.",
                 units_sent, escapes_predicted, mode_writes);
        $display("Checked %0d output units with random gaps and stalls on both streams.",
                 units_checked);
        if (errors == 0) begin
            $display("** html_entity_escape: PASSED **");
        end else begin
            $display("** html_entity_escape: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/hee_pkg.sv
sv/html_entity_escape.sv
sv/hee_checker.sv
tb/html_entity_escape_test.sv
